@@ hdl/srsd_pkg.sv @@
// Shared types and constants for the range size decimal block.
`timescale 1ns / 1ps

package srsd_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned HalfW = 64;
  localparam int unsigned DigitW = 4;
  // Range size is (NOT mask) + 1, one bit wider than the mask.
  localparam int unsigned SizeW = 2 * HalfW + 1;
  localparam int unsigned BitCntW = $clog2(SizeW);
  localparam int unsigned DigitCountDefault = 40;

  typedef enum logic [1:0] {
    StIdle,
    StConvert,
    StSkip,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic top_zero;
    logic remain_one;
  } status_t;

endpackage

@@ hdl/subnet_range_size_decimal.sv @@
// Sequence: the accept cycle loads the operands, bit-serial conversion follows, then the
// leading-zero skip (one shift per leading zero) runs before the first digit.
// One item at a time: a new item is accepted only in idle, after the last digit of the
// previous item has been taken, so any output stall also holds off the next item.
// Reset: rst_ni is asynchronous, active low, and returns the controller to idle.
`timescale 1ns / 1ps

module subnet_range_size_decimal #(
  parameter int unsigned DIGIT_COUNT = srsd_pkg::DigitCountDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [srsd_pkg::HalfW-1:0]  address_hi_i,
  input  logic [srsd_pkg::HalfW-1:0]  address_lo_i,
  input  logic [srsd_pkg::HalfW-1:0]  mask_hi_i,
  input  logic [srsd_pkg::HalfW-1:0]  mask_lo_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [srsd_pkg::HalfW-1:0]  broadcast_hi_o,
  output logic [srsd_pkg::HalfW-1:0]  broadcast_lo_o,
  output logic [srsd_pkg::DigitW-1:0] digit_o,
  output logic                        last_o
);

  srsd_pkg::cmd_t    cmd;
  srsd_pkg::status_t status;

  srsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srsd_dp #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .address_hi_i  (address_hi_i),
    .address_lo_i  (address_lo_i),
    .mask_hi_i     (mask_hi_i),
    .mask_lo_i     (mask_lo_i),
    .broadcast_hi_o(broadcast_hi_o),
    .broadcast_lo_o(broadcast_lo_o),
    .digit_o       (digit_o)
  );

  assign last_o = status.remain_one;

`ifndef ASSERT_OFF
  a_digit_is_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> digit_o <= srsd_pkg::DigitW'(9))
    else $error("emitted digit is not decimal");
  a_no_output_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result offered before conversion finished");
`endif

endmodule

@@ hdl/srsd_dp.sv @@
// Datapath: size register, bit-serial double dabble and digit shift-out.
`timescale 1ns / 1ps

module srsd_dp #(
  parameter int unsigned DIGIT_COUNT = srsd_pkg::DigitCountDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srsd_pkg::cmd_t                 cmd_i,
  output srsd_pkg::status_t              status_o,
  input  logic [srsd_pkg::HalfW-1:0]     address_hi_i,
  input  logic [srsd_pkg::HalfW-1:0]     address_lo_i,
  input  logic [srsd_pkg::HalfW-1:0]     mask_hi_i,
  input  logic [srsd_pkg::HalfW-1:0]     mask_lo_i,
  output logic [srsd_pkg::HalfW-1:0]     broadcast_hi_o,
  output logic [srsd_pkg::HalfW-1:0]     broadcast_lo_o,
  output logic [srsd_pkg::DigitW-1:0]    digit_o
);

  localparam int unsigned BcdW = DIGIT_COUNT * srsd_pkg::DigitW;
  localparam int unsigned RemW = $clog2(DIGIT_COUNT + 1);

  logic [srsd_pkg::SizeW-1:0] size_q, size_d;
  logic [BcdW-1:0]            bcd_q, bcd_d, bcd_adj;
  logic [srsd_pkg::HalfW-1:0] bcast_hi_q, bcast_hi_d;
  logic [srsd_pkg::HalfW-1:0] bcast_lo_q, bcast_lo_d;
  logic [RemW-1:0]            remain_q, remain_d;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (bcd_q[i*srsd_pkg::DigitW +: srsd_pkg::DigitW] >= srsd_pkg::DigitW'(5)) begin
        bcd_adj[i*srsd_pkg::DigitW +: srsd_pkg::DigitW] =
          bcd_q[i*srsd_pkg::DigitW +: srsd_pkg::DigitW] + srsd_pkg::DigitW'(3);
      end else begin
        bcd_adj[i*srsd_pkg::DigitW +: srsd_pkg::DigitW] =
          bcd_q[i*srsd_pkg::DigitW +: srsd_pkg::DigitW];
      end
    end
  end

  always_comb begin
    size_d     = size_q;
    bcd_d      = bcd_q;
    bcast_hi_d = bcast_hi_q;
    bcast_lo_d = bcast_lo_q;
    remain_d   = remain_q;
    if (cmd_i.load) begin
      size_d     = {1'b0, ~mask_hi_i, ~mask_lo_i} + srsd_pkg::SizeW'(1);
      bcd_d      = '0;
      bcast_hi_d = address_hi_i | ~mask_hi_i;
      bcast_lo_d = address_lo_i | ~mask_lo_i;
      remain_d   = RemW'(DIGIT_COUNT);
    end else if (cmd_i.dabble) begin
      bcd_d  = {bcd_adj[BcdW-2:0], size_q[srsd_pkg::SizeW-1]};
      size_d = {size_q[srsd_pkg::SizeW-2:0], 1'b0};
    end else if (cmd_i.shift) begin
      bcd_d    = {bcd_q[BcdW-srsd_pkg::DigitW-1:0], {srsd_pkg::DigitW{1'b0}}};
      remain_d = remain_q - RemW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    bcd_q      <= bcd_d;
    bcast_hi_q <= bcast_hi_d;
    bcast_lo_q <= bcast_lo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
    end else begin
      remain_q <= remain_d;
    end
  end

  assign digit_o             = bcd_q[BcdW-1 -: srsd_pkg::DigitW];
  assign status_o.top_zero   = (digit_o == '0);
  assign status_o.remain_one = (remain_q == RemW'(1));
  assign broadcast_hi_o      = bcast_hi_q;
  assign broadcast_lo_o      = bcast_lo_q;

`ifndef ASSERT_OFF
  a_shift_has_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> remain_q != '0)
    else $error("digit shift with no digits left");
  a_load_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !cmd_i.dabble && !cmd_i.shift)
    else $error("load issued together with another command");
`endif

endmodule

@@ hdl/srsd_ctrl.sv @@
// Controller: sequences load, conversion, zero skip and digit emission.
`timescale 1ns / 1ps

module srsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  srsd_pkg::status_t status_i,
  output srsd_pkg::cmd_t    cmd_o
);

  srsd_pkg::state_e state_q, state_d;
  logic [srsd_pkg::BitCntW-1:0] bit_cnt_q, bit_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= srsd_pkg::StIdle;
      bit_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      srsd_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          bit_cnt_d  = '0;
          state_d    = srsd_pkg::StConvert;
        end
      end
      srsd_pkg::StConvert: begin
        cmd_o.dabble = 1'b1;
        if (bit_cnt_q == srsd_pkg::BitCntW'(srsd_pkg::SizeW - 1)) begin
          state_d = srsd_pkg::StSkip;
        end else begin
          bit_cnt_d = bit_cnt_q + srsd_pkg::BitCntW'(1);
        end
      end
      srsd_pkg::StSkip: begin
        // Drop leading zeros, but always keep the final digit.
        if (status_i.top_zero && !status_i.remain_one) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = srsd_pkg::StEmit;
        end
      end
      srsd_pkg::StEmit: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.shift = 1'b1;
          if (status_i.remain_one) begin
            state_d = srsd_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = srsd_pkg::StIdle;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_starts_convert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == srsd_pkg::StConvert && bit_cnt_q == '0)
    else $error("accepted transfer did not start conversion");
  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && status_i.remain_one |=> state_q == srsd_pkg::StIdle)
    else $error("final digit transfer did not end the item");
`endif

endmodule
